FILE: sv/wti_pkg.sv
// shared types, constants and saturating helpers for the modal integrator
`default_nettype none
package wti_pkg;

	localparam int DefMaxModes = 64;
	localparam int IdxW = 6;
	localparam int ThetaW = 31;
	localparam int DtW = 40;
	localparam int CfgW = 40;
	localparam int InDataW = 168;
	localparam int OutDataW = 264;

	localparam logic [ThetaW-1:0] ThetaReset = 31'd375809638;
	localparam logic [DtW-1:0] DtReset = 40'd1099511628;
	localparam logic signed [63:0] TwoPiQ60 = 64'sh6487ED5110B4611A;
	localparam logic signed [63:0] SixQ32 = 64'sh0000_0006_0000_0000;
	localparam logic signed [63:0] ThreeQ32 = 64'sh0000_0003_0000_0000;
	localparam logic signed [63:0] SixInt = 64'sd6;
	localparam logic signed [63:0] SMax = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] SMin = 64'sh8000_0000_0000_0000;

	// configuration register indexes
	localparam logic CFG_THETA = 1'b0;
	localparam logic CFG_DT = 1'b1;

	// input command codes
	localparam logic CMD_INIT = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	typedef enum logic [1:0] {AK_MUL, AK_DIV, AK_IDIV} alu_kind_t;

	typedef struct packed {
		logic start;
		alu_kind_t kind;
		logic [5:0] sh;
	} alu_req_t;

	typedef enum logic [2:0] {AL_IDLE, AL_MUL, AL_NEG, AL_RND, AL_SHF, AL_DIV, AL_DFIN}
		alu_state_t;

	typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_ISSUE, ST_WAIT, ST_WRITE, ST_OUT}
		seq_state_t;

	typedef enum logic [4:0] {
		OP_W, OP_W2, OP_TAU, OP_TAU2, OP_DEN0, OP_DEN, OP_PF, OP_PW, OP_WT, OP_Q,
		OP_S6, OP_DA, OP_R, OP_RA, OP_VEL, OP_DV, OP_DD, OP_D6, OP_DIS
	} op_t;

	// saturating signed add
	function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
			logic signed [63:0] b);
		logic signed [63:0] s;
		begin
			s = a + b;
			if (a[63] == b[63] && s[63] != a[63])
				sat_add = a[63] ? SMin : SMax;
			else
				sat_add = s;
		end
	endfunction

	// saturating signed subtract
	function automatic logic signed [63:0] sat_sub(logic signed [63:0] a,
			logic signed [63:0] b);
		logic signed [63:0] s;
		begin
			s = a - b;
			if (a[63] != b[63] && s[63] != a[63])
				sat_sub = a[63] ? SMin : SMax;
			else
				sat_sub = s;
		end
	endfunction

	// magnitude of a signed word as unsigned
	function automatic logic [63:0] mag(logic signed [63:0] x);
		begin
			mag = x[63] ? 64'(-x) : 64'(x);
		end
	endfunction

endpackage
`default_nettype wire

FILE: sv/wti_alu.sv
// shared bit-serial multiplier with rounding and restoring divider, both saturating
`default_nettype none
module wti_alu
	import wti_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire alu_req_t req,
	input wire logic signed [63:0] x,
	input wire logic signed [63:0] y,
	output logic done,
	output logic signed [63:0] res
);

	alu_state_t st_q, st_d;
	logic [63:0] ca_q;
	logic [127:0] prod_q;
	logic neg_q;
	logic [5:0] sh_q;
	logic [6:0] cnt_q;
	logic [63:0] dv_q;
	logic [127:0] num_q;
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic over_q;
	logic done_q;
	logic signed [63:0] res_q;

	logic [64:0] msum;
	logic [64:0] rs;
	logic qbit;
	logic signed [127:0] shifted;
	logic [63:0] limit;
	logic div_zero;

	assign done = done_q;
	assign res = res_q;
	assign div_zero = (y == 64'sd0);

	// serial step arithmetic
	always_comb begin
		msum = {1'b0, prod_q[127:64]} + (prod_q[0] ? {1'b0, ca_q} : 65'd0);
		rs = {rem_q, num_q[127]};
		qbit = (rs >= {1'b0, dv_q});
		shifted = $signed(prod_q) >>> sh_q;
		limit = neg_q ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			AL_IDLE: begin
				if (req.start) begin
					if (req.kind == AK_MUL)
						st_d = AL_MUL;
					else if (!div_zero)
						st_d = AL_DIV;
				end
			end
			AL_MUL: if (cnt_q == 7'd0) st_d = AL_NEG;
			AL_NEG: st_d = AL_RND;
			AL_RND: st_d = AL_SHF;
			AL_SHF: st_d = AL_IDLE;
			AL_DIV: if (cnt_q == 7'd0) st_d = AL_DFIN;
			AL_DFIN: st_d = AL_IDLE;
			default: st_d = AL_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= AL_IDLE;
			done_q <= 1'b0;
		end else begin
			st_q <= st_d;
			done_q <= (st_q == AL_SHF) || (st_q == AL_DFIN) ||
				(st_q == AL_IDLE && req.start && req.kind != AK_MUL && div_zero);
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (st_q)
			AL_IDLE: begin
				neg_q <= x[63] ^ y[63];
				sh_q <= req.sh;
				ca_q <= mag(x);
				prod_q <= {64'd0, mag(y)};
				dv_q <= mag(y);
				rem_q <= '0;
				quo_q <= '0;
				over_q <= 1'b0;
				if (req.kind == AK_MUL) begin
					cnt_q <= 7'd63;
				end else begin
					cnt_q <= 7'd127;
				end
				if (req.kind == AK_DIV)
					num_q <= {32'd0, mag(x), 32'd0};
				else
					num_q <= {64'd0, mag(x)};
				if (x > 64'sd0)
					res_q <= SMax;
				else if (x < 64'sd0)
					res_q <= SMin;
				else
					res_q <= 64'sd0;
			end
			AL_MUL: begin
				prod_q <= {msum, prod_q[63:1]};
				cnt_q <= cnt_q - 7'd1;
			end
			AL_NEG: if (neg_q) prod_q <= ~prod_q + 128'd1;
			AL_RND: prod_q <= prod_q + (128'd1 << (sh_q - 6'd1));
			AL_SHF: begin
				if (shifted[127:64] != {64{shifted[63]}})
					res_q <= shifted[127] ? SMin : SMax;
				else
					res_q <= shifted[63:0];
			end
			AL_DIV: begin
				rem_q <= qbit ? 64'(rs - {1'b0, dv_q}) : rs[63:0];
				num_q <= {num_q[126:0], 1'b0};
				if (cnt_q[6])
					over_q <= over_q | qbit;
				else
					quo_q <= {quo_q[62:0], qbit};
				cnt_q <= cnt_q - 7'd1;
			end
			AL_DFIN: begin
				if (over_q || quo_q > limit)
					res_q <= neg_q ? SMin : SMax;
				else
					res_q <= neg_q ? -$signed(quo_q) : $signed(quo_q);
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

FILE: sv/modal_wilson_theta_integrator.sv
// top level: per-mode state memories and the Wilson-theta step sequencer
//
// Input words arrive on s_tvalid/s_tready/s_tdata with the command on s_tuser
// (0 = load a mode, 1 = advance a mode one step). Every word yields exactly one
// result word on m_tvalid/m_tready/m_tdata.
// Theta and the time step are written through cfg_we/cfg_addr/cfg_wdata while
// the block is idle; they take effect on the next word.
// One word is in work at a time. All multiplies and divides go through one shared
// unit, a bit-serial multiplier and a restoring divider; a divide by zero skips the
// serial steps.
// A load takes two multiplies; a step takes 14 multiplies and 3 divides. A mode
// index at or beyond MAX_MODES returns its index with zero fields and leaves all
// state alone.
// The result sits in an output register; the next word is accepted as soon as
// it is handed there, so a stalled receiver only holds a finished result and
// stops new results from being delivered, never loses one.
// Reset returns theta and the time step to their defaults and empties the
// pipeline; the mode memories are not cleared and must be loaded before use.
`default_nettype none
module modal_wilson_theta_integrator
	import wti_pkg::*;
#(
	parameter int MAX_MODES = DefMaxModes
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic cfg_addr,
	input wire logic [CfgW-1:0] cfg_wdata,
	input wire logic s_tvalid,
	output logic s_tready,
	// mode_index, force_req, frequency, initial_velocity, zero fill
	input wire logic [InDataW-1:0] s_tdata,
	// command
	input wire logic s_tuser,
	output logic m_tvalid,
	input wire logic m_tready,
	// out_mode_index, displacement, velocity, acceleration, displacement_change, zero fill
	output logic [OutDataW-1:0] m_tdata
);

	localparam int AW = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;

	// state memories
	logic signed [63:0] mem_d [MAX_MODES];
	logic signed [63:0] mem_v [MAX_MODES];
	logic signed [63:0] mem_a [MAX_MODES];
	logic signed [63:0] mem_f [MAX_MODES];
	logic signed [63:0] mem_w [MAX_MODES];
	logic signed [63:0] rd_d_q, rd_v_q, rd_a_q, rd_f_q, rd_w_q;

	logic [ThetaW-1:0] theta_q;
	logic [DtW-1:0] dt_q;

	seq_state_t st_q, st_d;
	op_t op_q;
	logic cmd_q;
	logic [IdxW-1:0] idx_q;
	logic signed [63:0] force_q, ivel_q;
	logic [31:0] freq_q;
	logic oor;
	logic [AW-1:0] addr;

	logic signed [63:0] tau_q, t_q, den_q, p_q, acc_q, vel_q, dis_q, dchg_q;

	logic m_tvalid_q;
	logic [OutDataW-1:0] m_tdata_q;
	logic [OutDataW-1:0] res_word;

	alu_req_t req;
	logic signed [63:0] ax, ay;
	logic alu_done;
	logic signed [63:0] alu_res;
	logic signed [63:0] th, dt;

	assign th = {33'd0, theta_q};
	assign dt = {24'd0, dt_q};
	assign addr = AW'(idx_q);
	assign oor = ({5'd0, idx_q} >= 11'(MAX_MODES));
	assign s_tready = (st_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	wti_alu u_alu (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.x(ax),
		.y(ay),
		.done(alu_done),
		.res(alu_res)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			theta_q <= ThetaReset;
			dt_q <= DtReset;
		end else if (cfg_we) begin
			if (cfg_addr == CFG_THETA)
				theta_q <= cfg_wdata[ThetaW-1:0];
			if (cfg_addr == CFG_DT)
				dt_q <= cfg_wdata[DtW-1:0];
		end
	end

	// operand selection for the shared unit
	always_comb begin
		req.start = (st_q == ST_ISSUE);
		req.kind = AK_MUL;
		req.sh = 6'd32;
		ax = th;
		ay = dt;
		case (op_q)
			OP_W: begin
				ax = TwoPiQ60; ay = {32'd0, freq_q}; req.sh = 6'd44;
			end
			OP_W2: begin
				ax = t_q; ay = t_q;
			end
			OP_TAU: req.sh = 6'd8;
			OP_TAU2: begin
				ax = tau_q; ay = tau_q; req.sh = 6'd62;
			end
			OP_DEN0: begin
				ax = rd_w_q; ay = t_q; req.sh = 6'd58;
			end
			OP_DEN: begin
				ay = den_q; req.sh = 6'd28;
			end
			OP_PF: begin
				ay = sat_sub(force_q, rd_f_q); req.sh = 6'd28;
			end
			OP_PW: begin
				ax = rd_w_q; ay = rd_d_q;
			end
			OP_WT: begin
				ax = rd_w_q; ay = tau_q; req.sh = 6'd60;
			end
			OP_Q: begin
				ax = t_q; ay = rd_v_q;
			end
			OP_S6: begin
				ax = t_q; ay = SixQ32;
			end
			OP_DA: begin
				ax = t_q; ay = den_q; req.kind = AK_DIV;
			end
			OP_R: begin
				ax = ThreeQ32; ay = {29'd0, theta_q, 4'd0}; req.kind = AK_DIV;
			end
			OP_RA: begin
				ax = t_q; ay = rd_a_q;
			end
			OP_VEL: begin
				ay = sat_add(acc_q, rd_a_q); ax = dt; req.sh = 6'd41;
			end
			OP_DV: begin
				ax = dt; ay = rd_v_q; req.sh = 6'd40;
			end
			OP_DD: begin
				ax = dt; ay = dt; req.sh = 6'd18;
			end
			OP_D6: begin
				ax = t_q; ay = SixInt; req.kind = AK_IDIV;
			end
			OP_DIS: begin
				ax = t_q; ay = sat_add(acc_q, sat_add(rd_a_q, rd_a_q)); req.sh = 6'd62;
			end
			default: ;
		endcase
	end

	// sequencer next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (s_tvalid) st_d = ST_READ;
			ST_READ: st_d = oor ? ST_OUT : ST_ISSUE;
			ST_ISSUE: st_d = ST_WAIT;
			ST_WAIT: begin
				if (alu_done)
					st_d = (op_q == OP_W2 || op_q == OP_DIS) ? ST_WRITE : ST_ISSUE;
			end
			ST_WRITE: st_d = ST_OUT;
			ST_OUT: if (!m_tvalid_q || m_tready) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_OUT && (!m_tvalid_q || m_tready))
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// result word assembly
	always_comb begin
		res_word = '0;
		res_word[5:0] = idx_q;
		if (!oor) begin
			if (cmd_q == CMD_INIT) begin
				res_word[133:70] = ivel_q;
				res_word[197:134] = force_q;
			end else begin
				res_word[69:6] = dis_q;
				res_word[133:70] = vel_q;
				res_word[197:134] = acc_q;
				res_word[261:198] = dchg_q;
			end
		end
	end

	// capture, op sequencing and write-back
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && s_tvalid) begin
			cmd_q <= s_tuser;
			idx_q <= s_tdata[5:0];
			force_q <= s_tdata[69:6];
			freq_q <= s_tdata[101:70];
			ivel_q <= s_tdata[165:102];
			op_q <= (s_tuser == CMD_INIT) ? OP_W : OP_TAU;
		end
		if (st_q == ST_WAIT && alu_done) begin
			if (op_q != OP_W2 && op_q != OP_DIS)
				op_q <= op_t'(op_q + 5'd1);
			case (op_q)
				OP_W: t_q <= alu_res;
				OP_W2: t_q <= alu_res;
				OP_TAU: tau_q <= alu_res;
				OP_TAU2: t_q <= alu_res;
				OP_DEN0: den_q <= sat_add(SixQ32, alu_res);
				OP_DEN: den_q <= alu_res;
				OP_PF: p_q <= sat_add(sat_add(rd_f_q, alu_res), sat_add(rd_a_q, rd_a_q));
				OP_PW: p_q <= sat_sub(p_q, alu_res);
				OP_WT: t_q <= alu_res;
				OP_Q: t_q <= sat_sub(p_q, alu_res);
				OP_S6: t_q <= alu_res;
				OP_DA: acc_q <= alu_res;
				OP_R: t_q <= alu_res;
				OP_RA: acc_q <= sat_add(sat_sub(acc_q, alu_res), rd_a_q);
				OP_VEL: vel_q <= sat_add(rd_v_q, alu_res);
				OP_DV: dis_q <= sat_add(rd_d_q, alu_res);
				OP_DD: t_q <= alu_res;
				OP_D6: t_q <= alu_res;
				OP_DIS: dis_q <= sat_add(dis_q, alu_res);
				default: ;
			endcase
		end
		// increment against the displacement read before write-back
		if (st_q == ST_WRITE)
			dchg_q <= sat_sub(dis_q, rd_d_q);
		// result word
		if (st_q == ST_OUT && (!m_tvalid_q || m_tready))
			m_tdata_q <= res_word;
	end

	// mode memories: registered read, at most one write per word
	always_ff @(posedge clk) begin
		rd_d_q <= mem_d[addr];
		rd_v_q <= mem_v[addr];
		rd_a_q <= mem_a[addr];
		rd_f_q <= mem_f[addr];
		rd_w_q <= mem_w[addr];
		if (st_q == ST_WRITE) begin
			mem_f[addr] <= force_q;
			if (cmd_q == CMD_INIT) begin
				mem_d[addr] <= 64'sd0;
				mem_v[addr] <= ivel_q;
				mem_a[addr] <= force_q;
				mem_w[addr] <= t_q;
			end else begin
				mem_d[addr] <= dis_q;
				mem_v[addr] <= vel_q;
				mem_a[addr] <= acc_q;
			end
		end
	end

endmodule
`default_nettype wire
